// ===== rtl/mmhps_pkg.sv =====
// Package for the masked multi-hit priority scanner.
// Holds the channel payload types, command and result codes, and parameter defaults.
// No dependencies.
package mmhps_pkg;

   localparam int MAX_HITS_DEF   = 8;
   localparam int SCAN_WORDS_DEF = 20;
   localparam int MODE_ROWS_DEF  = 32;

   localparam int ROW_W  = 5;
   localparam int WORD_W = 5;
   localparam int DATA_W = 16;
   localparam int MODE_W = 32;
   localparam int BIT_W  = 4;
   localparam int NUM_W  = 9;
   localparam int SLOT_W = 3;
   localparam int CNT_W  = 4;

   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_STATUS = 1'b1;

   localparam logic KIND_HIT     = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef struct packed {
      logic              cmd;
      logic [ROW_W-1:0]  pattern_row;
      logic [WORD_W-1:0] word_index;
      logic [DATA_W-1:0] data_word;
      logic [MODE_W-1:0] mode_select;
   } req_type;

   typedef struct packed {
      logic              kind;
      logic [NUM_W-1:0]  hit_number;
      logic [SLOT_W-1:0] slot;
      logic [CNT_W-1:0]  hit_count;
      logic              list_changed;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic             valid;
      logic [NUM_W-1:0] number;
   } entry_type;

endpackage

// ===== rtl/masked_multi_hit_priority_scan.sv =====
// Masked multi-hit priority scanner, top level.
// Pattern table memory, status word pipeline and result sequencer; uses mmhps_pkg.
//
// Pattern writes and status words are taken one per cycle unless the status stages are full.
// A status word reads its mask word from the single-port pattern memory into a register, then
// the result sequencer sends one result per cycle while rsp_ready is high: one per hit reported
// (at most MAX_HITS per scan) plus a summary after the last word. The next word enters while
// the previous one drains; a word with no results leaves the sequencer sending nothing.
// The pattern memory needs no clearing pass; unwritten mask words read as unknown.
module masked_multi_hit_priority_scan #(
   parameter int MAX_HITS   = mmhps_pkg::MAX_HITS_DEF,
   parameter int SCAN_WORDS = mmhps_pkg::SCAN_WORDS_DEF,
   parameter int MODE_ROWS  = mmhps_pkg::MODE_ROWS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  mmhps_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output mmhps_pkg::rsp_type rsp_data
);
   import mmhps_pkg::*;

   localparam int DEPTH = MODE_ROWS * SCAN_WORDS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(MAX_HITS + 1);
   localparam int IW    = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;

   logic [DATA_W-1:0] pattern_mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   logic [ROW_W-1:0]  active_row_ff;
   logic [ROW_W-1:0]  scan_row;
   logic [ROW_W-1:0]  mode_row;
   logic              req_xfer;
   logic              wr_en;
   logic              rd_en;
   logic [AW-1:0]     wr_addr;
   logic [AW-1:0]     rd_addr;

   logic              s1_valid_ff;
   logic [WORD_W-1:0] s1_word_ff;
   logic [DATA_W-1:0] s1_status_ff;

   logic              e_valid_ff;
   logic [WORD_W-1:0] e_word_ff;
   logic [DATA_W-1:0] e_hits_ff;
   logic              e_summary_ff;

   logic [CW-1:0]     found_count_ff;
   entry_type         hit_list_ff  [MAX_HITS];
   entry_type         prev_list_ff [MAX_HITS];

   logic              room;
   logic [DATA_W-1:0] cur_hits;
   logic [DATA_W-1:0] rest_hits;
   logic              has_hit;
   logic [BIT_W-1:0]  hit_bit;
   logic              more;
   logic              changed;
   logic              rsp_xfer;
   logic              e_done;
   logic              e_free;
   logic              s1_move;
   logic [CW-1:0]     found_count_in;

   // Row select: lowest set mode bit at word 0, else hold the active row.
   always_comb begin
      mode_row = '0;
      for (int b = MODE_ROWS - 1; b >= 0; b--) begin
         if (req_data.mode_select[b]) begin
            mode_row = ROW_W'(b);
         end
      end
   end

   assign scan_row = (req_data.word_index == '0) ? mode_row : active_row_ff;
   assign req_xfer = req_valid && req_ready;
   assign wr_en    = req_xfer && (req_data.cmd == CMD_WRITE)
                     && (int'(req_data.pattern_row) < MODE_ROWS)
                     && (int'(req_data.word_index) < SCAN_WORDS);
   assign rd_en    = req_xfer && (req_data.cmd == CMD_STATUS)
                     && (int'(req_data.word_index) < SCAN_WORDS);
   assign wr_addr  = AW'(int'(req_data.pattern_row) * SCAN_WORDS + int'(req_data.word_index));
   assign rd_addr  = AW'(int'(scan_row) * SCAN_WORDS + int'(req_data.word_index));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pattern_mem[wr_addr] <= req_data.data_word;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= pattern_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_row_ff <= '0;
      end else if (rd_en && req_data.word_index == '0) begin
         active_row_ff <= mode_row;
      end
   end

   // Result sequencer
   assign room     = int'(found_count_ff) < MAX_HITS;
   assign cur_hits = room ? e_hits_ff : '0;
   assign has_hit  = |cur_hits;
   assign rest_hits = cur_hits & (cur_hits - DATA_W'(1));
   assign more     = (|rest_hits) && ((int'(found_count_ff) + 1) < MAX_HITS);

   always_comb begin
      hit_bit = '0;
      for (int b = DATA_W - 1; b >= 0; b--) begin
         if (cur_hits[b]) begin
            hit_bit = BIT_W'(b);
         end
      end
   end

   always_comb begin
      changed = 1'b0;
      for (int i = 0; i < MAX_HITS; i++) begin
         if (hit_list_ff[i] != prev_list_ff[i]) begin
            changed = 1'b1;
         end
      end
   end

   always_comb begin
      rsp_data = '0;
      if (has_hit) begin
         rsp_data.kind       = KIND_HIT;
         rsp_data.hit_number = {e_word_ff, hit_bit};
         rsp_data.slot       = SLOT_W'(found_count_ff);
         rsp_data.last       = !more && !e_summary_ff;
      end else begin
         rsp_data.kind         = KIND_SUMMARY;
         rsp_data.hit_count    = CNT_W'(found_count_ff);
         rsp_data.list_changed = changed;
         rsp_data.last         = 1'b1;
      end
   end

   assign rsp_valid = e_valid_ff && (has_hit || e_summary_ff);
   assign rsp_xfer  = rsp_valid && rsp_ready;
   assign e_done    = e_valid_ff && (!(has_hit || e_summary_ff) || (rsp_xfer && rsp_data.last));
   assign e_free    = !e_valid_ff || e_done;
   assign s1_move   = s1_valid_ff && e_free;
   assign req_ready = !s1_valid_ff || e_free;

   always_comb begin
      found_count_in = found_count_ff;
      if (rsp_xfer && has_hit) begin
         found_count_in = found_count_ff + CW'(1);
      end
      if (s1_move && s1_word_ff == '0) begin
         found_count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (rd_en) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         s1_word_ff   <= req_data.word_index;
         s1_status_ff <= req_data.data_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (s1_move) begin
         e_valid_ff <= 1'b1;
      end else if (e_done) begin
         e_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         e_word_ff    <= s1_word_ff;
         e_hits_ff    <= s1_status_ff & rd_data_ff;
         e_summary_ff <= int'(s1_word_ff) == SCAN_WORDS - 1;
      end else if (rsp_xfer) begin
         if (has_hit) begin
            e_hits_ff <= rest_hits;
         end else begin
            e_summary_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_count_ff <= '0;
         for (int i = 0; i < MAX_HITS; i++) begin
            hit_list_ff[i]  <= '0;
            prev_list_ff[i] <= '0;
         end
      end else begin
         found_count_ff <= found_count_in;
         if (rsp_xfer && has_hit) begin
            hit_list_ff[found_count_ff[IW-1:0]] <= '{valid: 1'b1, number: {e_word_ff, hit_bit}};
         end
         if (rsp_xfer && !has_hit) begin
            for (int i = 0; i < MAX_HITS; i++) begin
               prev_list_ff[i] <= hit_list_ff[i];
            end
         end
         if (s1_move && s1_word_ff == '0) begin
            for (int i = 0; i < MAX_HITS; i++) begin
               hit_list_ff[i] <= '0;
            end
         end
      end
   end

endmodule
